// ===== hw/rtl/tftp_pkg.sv =====
// ----------------------------------------------------------------------------
// TFTP transfer engine package
// Codes, state encoding and result record shared by the transfer engine.
// ----------------------------------------------------------------------------
package tftp_pkg;

	localparam int MaxBlockBytesDef = 512;
	localparam int MaxResults       = 3;

	localparam logic [9:0] BlockSizeRst  = 10'd512;
	localparam logic [7:0] RetryLimitRst = 8'd5;
	localparam logic [9:0] HeaderLen     = 10'd4;

	typedef enum logic [1:0] {
		CMD_REQUEST = 2'd0,
		CMD_PACKET  = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_CHUNK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_RRQ   = 3'd1,
		OP_WRQ   = 3'd2,
		OP_DATA  = 3'd3,
		OP_ACK   = 3'd4,
		OP_ERROR = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_SEND    = 2'd0,
		ACT_DELIVER = 2'd1,
		ACT_FETCH   = 2'd2,
		ACT_END     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_FETCH    = 2'd1,
		MODE_WAIT_ACK = 2'd2,
		MODE_WRITE    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		CFG_BLOCK_SIZE  = 4'd0,
		CFG_RETRY_LIMIT = 4'd1
	} cfg_index_t;

	localparam logic [2:0] ErrNone    = 3'd0;
	localparam logic [2:0] ErrIllegal = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  send_opcode;
		logic [15:0] send_block;
		logic [9:0]  send_length;
		logic [2:0]  error_code;
		logic        end_status;
	} result_t;

	localparam result_t ResultNone = '0;

endpackage

// ===== hw/rtl/tftp_block_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// TFTP block transfer engine
// Lockstep server session engine for read and write transfers.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel: tuser holds the command, tdata holds
// pkt_opcode, pkt_block, data_length and sink_ok from the lowest bit up.
// Each event causes zero to three result items on m_axis: tuser holds the
// action, tdata holds the packet fields, and tlast marks the final result of
// the event. Registers blksize and retry_limit are written on the cfg
// channel, which is always ready; the user must write them only while no
// item is in flight; the block does not enforce it. Results of an accepted
// item appear the cycle after acceptance. The event logic is combinational,
// so the block takes one item per cycle as long as each item causes at most
// one result and the receiver is ready. An item with k results holds the
// result buffer until all are taken; the next item is accepted in the cycle
// that takes the last. Items that cause no result never stall the input.
// Reset clears the session to idle, block and retry counters to zero and the
// registers to blksize 512 and retry_limit 5. When the receiver stalls,
// the pending result holds and the input stays stalled behind it.
// ----------------------------------------------------------------------------
module tftp_block_transfer_engine #(
	parameter int MAX_BLOCK_BYTES = tftp_pkg::MaxBlockBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pkt_opcode[2:0], pkt_block[18:3], data_length[28:19], sink_ok[29]
	input  logic [31:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// send_opcode[2:0], send_block[18:3], send_length[28:19],
	// error_code[31:29], end_status[32]
	output logic [39:0] m_axis_tdata,
	// action[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import tftp_pkg::*;

	localparam logic [16:0] MaxBlk = 17'(MAX_BLOCK_BYTES);

	logic [9:0]  blksize_q;
	logic [7:0]  retry_limit_q;
	mode_t       mode_q, mode_d;
	logic [15:0] block_q, block_d;
	logic [7:0]  retry_q, retry_d;
	logic [9:0]  chunk_q, chunk_d;

	result_t     res_s1 [MaxResults];
	result_t     res_d  [MaxResults];
	logic [1:0]  cnt_s1, cnt_d;
	logic [1:0]  rd_q;

	cmd_t        cmd;
	logic [2:0]  opc;
	logic [15:0] pblock;
	logic [9:0]  dlen;
	logic        sink;
	logic [9:0]  eff_bs;
	logic [9:0]  chunk_new;
	logic        ack_ok;
	logic        data_ok;
	logic        retry_out;
	logic        in_acc;
	logic        out_acc;
	logic        buf_empty;
	logic        out_last;
	result_t     res_out;

	assign cmd    = cmd_t'(s_axis_tuser);
	assign opc    = s_axis_tdata[2:0];
	assign pblock = s_axis_tdata[18:3];
	assign dlen   = s_axis_tdata[28:19];
	assign sink   = s_axis_tdata[29];

	assign eff_bs    = ({7'd0, blksize_q} < MaxBlk) ? blksize_q : MaxBlk[9:0];
	assign chunk_new = (dlen < eff_bs) ? dlen : eff_bs;
	assign ack_ok    = (cmd == CMD_PACKET) && (opc == OP_ACK) && (pblock == block_q);
	assign data_ok   = (opc == OP_DATA) && (pblock == block_q);
	assign retry_out = (retry_q >= retry_limit_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blksize_q     <= BlockSizeRst;
			retry_limit_q <= RetryLimitRst;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BLOCK_SIZE) begin
				blksize_q <= cfg_data;
			end else if (cfg_index == CFG_RETRY_LIMIT) begin
				retry_limit_q <= cfg_data[7:0];
			end
		end
	end

	always_comb begin
		mode_d  = mode_q;
		block_d = block_q;
		retry_d = retry_q;
		chunk_d = chunk_q;
		unique case (cmd)
			CMD_REQUEST: begin
				if (mode_q == MODE_IDLE) begin
					if (opc == OP_RRQ) begin
						mode_d  = MODE_FETCH;
						block_d = 16'd1;
						retry_d = 8'd0;
					end else if (opc == OP_WRQ) begin
						mode_d  = MODE_WRITE;
						block_d = 16'd1;
						retry_d = 8'd0;
					end
				end
			end
			CMD_CHUNK: begin
				if (mode_q == MODE_FETCH) begin
					chunk_d = chunk_new;
					if (retry_limit_q == 8'd0) begin
						mode_d = MODE_IDLE;
					end else begin
						retry_d = 8'd1;
						mode_d  = MODE_WAIT_ACK;
					end
				end
			end
			default: begin
				if (mode_q == MODE_WAIT_ACK) begin
					if (ack_ok) begin
						if (chunk_q < eff_bs) begin
							mode_d = MODE_IDLE;
						end else begin
							block_d = block_q + 16'd1;
							retry_d = 8'd0;
							mode_d  = MODE_FETCH;
						end
					end else if (retry_out) begin
						mode_d = MODE_IDLE;
					end else begin
						retry_d = retry_q + 8'd1;
					end
				end else if (mode_q == MODE_WRITE) begin
					if (cmd == CMD_TIMEOUT || opc == OP_ERROR) begin
						mode_d = MODE_IDLE;
					end else if (data_ok) begin
						if (!sink || dlen < eff_bs) begin
							mode_d = MODE_IDLE;
						end else begin
							block_d = block_q + 16'd1;
						end
					end
				end
			end
		endcase
	end

	always_comb begin
		res_d[0] = ResultNone;
		res_d[1] = ResultNone;
		res_d[2] = ResultNone;
		cnt_d    = 2'd0;
		unique case (cmd)
			CMD_REQUEST: begin
				if (mode_q == MODE_IDLE) begin
					cnt_d = 2'd1;
					if (opc == OP_RRQ) begin
						res_d[0].action     = ACT_FETCH;
						res_d[0].send_block = 16'd1;
					end else if (opc == OP_WRQ) begin
						res_d[0].action      = ACT_SEND;
						res_d[0].send_opcode = OP_ACK;
						res_d[0].send_length = HeaderLen;
					end else begin
						res_d[0].action      = ACT_SEND;
						res_d[0].send_opcode = OP_ERROR;
						res_d[0].send_length = HeaderLen;
						res_d[0].error_code  = ErrIllegal;
					end
				end
			end
			CMD_CHUNK: begin
				if (mode_q == MODE_FETCH) begin
					cnt_d = 2'd1;
					if (retry_limit_q == 8'd0) begin
						res_d[0].action     = ACT_END;
						res_d[0].end_status = 1'b1;
					end else begin
						res_d[0].action      = ACT_SEND;
						res_d[0].send_opcode = OP_DATA;
						res_d[0].send_block  = block_q;
						res_d[0].send_length = chunk_new + HeaderLen;
					end
				end
			end
			default: begin
				if (mode_q == MODE_WAIT_ACK) begin
					cnt_d = 2'd1;
					if (ack_ok) begin
						if (chunk_q < eff_bs) begin
							res_d[0].action = ACT_END;
						end else begin
							res_d[0].action     = ACT_FETCH;
							res_d[0].send_block = block_q + 16'd1;
						end
					end else if (retry_out) begin
						res_d[0].action     = ACT_END;
						res_d[0].end_status = 1'b1;
					end else begin
						res_d[0].action      = ACT_SEND;
						res_d[0].send_opcode = OP_DATA;
						res_d[0].send_block  = block_q;
						res_d[0].send_length = chunk_q + HeaderLen;
					end
				end else if (mode_q == MODE_WRITE) begin
					if (cmd == CMD_TIMEOUT || opc == OP_ERROR) begin
						cnt_d               = 2'd1;
						res_d[0].action     = ACT_END;
						res_d[0].end_status = 1'b1;
					end else if (data_ok) begin
						res_d[0].action      = ACT_DELIVER;
						res_d[0].send_block  = block_q;
						res_d[0].send_length = dlen;
						if (!sink) begin
							cnt_d               = 2'd2;
							res_d[1].action     = ACT_END;
							res_d[1].end_status = 1'b1;
						end else begin
							res_d[1].action      = ACT_SEND;
							res_d[1].send_opcode = OP_ACK;
							res_d[1].send_block  = block_q;
							res_d[1].send_length = HeaderLen;
							if (dlen < eff_bs) begin
								cnt_d           = 2'd3;
								res_d[2].action = ACT_END;
							end else begin
								cnt_d = 2'd2;
							end
						end
					end
				end
			end
		endcase
	end

	assign buf_empty     = (rd_q == cnt_s1);
	assign out_last      = ((rd_q + 2'd1) == cnt_s1);
	assign m_axis_tvalid = !buf_empty;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = buf_empty || (out_acc && out_last);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			block_q <= 16'd0;
			retry_q <= 8'd0;
			chunk_q <= 10'd0;
			cnt_s1  <= 2'd0;
			rd_q    <= 2'd0;
		end else if (in_acc) begin
			mode_q  <= mode_d;
			block_q <= block_d;
			retry_q <= retry_d;
			chunk_q <= chunk_d;
			cnt_s1  <= cnt_d;
			rd_q    <= 2'd0;
		end else if (out_acc) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1[0] <= res_d[0];
			res_s1[1] <= res_d[1];
			res_s1[2] <= res_d[2];
		end
	end

	always_comb begin
		unique case (rd_q)
			2'd0:    res_out = res_s1[0];
			2'd1:    res_out = res_s1[1];
			2'd2:    res_out = res_s1[2];
			default: res_out = ResultNone;
		endcase
	end

	assign m_axis_tuser = res_out.action;
	assign m_axis_tlast = out_last;
	assign m_axis_tdata = {7'd0, res_out.end_status, res_out.error_code,
		res_out.send_length, res_out.send_block, res_out.send_opcode};

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_s1)
		else $error("result read index passed the result count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
		else $error("item accepted while earlier results are still pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ACT_END) |-> m_axis_tlast)
		else $error("session end is not the last result of its item");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ACT_END) |-> (mode_q == MODE_IDLE))
		else $error("session end reported while the session stays active");

endmodule

// ===== tb/tftp_block_transfer_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TFTP block transfer engine testbench
// Drives session events into the engine and compares every result item with
// a cycle-free model of the read and write sessions kept in this bench, or
// with the reply listed in the table for some directed events. The short
// table of directed events comes first, followed by random phases of mostly
// well-formed sessions under several register settings. Both stream sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tftp_block_transfer_engine_tb;
	import tftp_pkg::*;

	localparam logic [9:0] MaxBytes       = 10'(MaxBlockBytesDef);
	localparam logic [3:0] CfgUnmapped    = 4'hF;
	localparam int         LongHoldCycles = 200;
	localparam int         WatchdogLimit  = 3000;
	localparam int         TailCycles     = 4;

	typedef struct packed {
		result_t res;
		logic    last;
	} reply_t;

	typedef struct packed {
		logic        is_cfg;
		logic [3:0]  reg_index;
		logic [9:0]  reg_value;
		logic [1:0]  cmd;
		logic [2:0]  op;
		logic [15:0] blk;
		logic [9:0]  len;
		logic        sink;
		logic        typed;
		reply_t      want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [9:0]  cfg_data;

	// Session model state and its copy of the registers.
	mode_t       sess_mode       = MODE_IDLE;
	logic [15:0] cur_block       = '0;
	logic [7:0]  retry_cnt       = '0;
	logic [9:0]  chunk_len       = '0;
	logic [9:0]  reg_blksize     = BlockSizeRst;
	logic [7:0]  reg_retry_limit = RetryLimitRst;

	reply_t      step_replies[$];
	reply_t      expected_replies[$];
	stim_row_t   directed_rows[$];

	int          failures        = 0;
	int          items_sent      = 0;
	int          items_effective = 0;
	int          replies_seen    = 0;
	int          settings_done   = 0;
	int          sessions_ok     = 0;
	int          sessions_failed = 0;
	int          quiet_cycles    = 0;
	int          burst_left      = 1;
	bit          gaps_on         = 1'b1;
	logic        long_hold       = 1'b0;

	tftp_block_transfer_engine #(
		.MAX_BLOCK_BYTES(MaxBlockBytesDef)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic reply_t make_reply(logic [1:0] act, logic [2:0] op, logic [15:0] blk,
			logic [9:0] len, logic [2:0] err, logic st, logic lst);
		reply_t r;
		r.res.action      = act;
		r.res.send_opcode = op;
		r.res.send_block  = blk;
		r.res.send_length = len;
		r.res.error_code  = err;
		r.res.end_status  = st;
		r.last            = lst;
		return r;
	endfunction

	function automatic logic [9:0] eff_size();
		return (reg_blksize < MaxBytes) ? reg_blksize : MaxBytes;
	endfunction

	function automatic void emit(logic [1:0] act, logic [2:0] op, logic [15:0] blk,
			logic [9:0] len, logic [2:0] err, logic st);
		step_replies.push_back(make_reply(act, op, blk, len, err, st, 1'b0));
	endfunction

	function automatic void close_session(logic st);
		sess_mode = MODE_IDLE;
		if (st)
			sessions_failed++;
		else
			sessions_ok++;
		emit(ACT_END, OP_NONE, '0, '0, ErrNone, st);
	endfunction

	function automatic void send_chunk();
		emit(ACT_SEND, OP_DATA, cur_block, chunk_len + HeaderLen, ErrNone, 1'b0);
	endfunction

	// Advances the session model by one event and stages its result items.
	function automatic void predict_event(logic [1:0] cmd, logic [2:0] op, logic [15:0] blk,
			logic [9:0] len, logic sink);
		logic [9:0] eff;
		eff = eff_size();
		case (cmd)
			CMD_REQUEST: begin
				if (sess_mode == MODE_IDLE) begin
					if (op == OP_RRQ) begin
						sess_mode = MODE_FETCH;
						cur_block = 16'd1;
						retry_cnt = '0;
						emit(ACT_FETCH, OP_NONE, cur_block, '0, ErrNone, 1'b0);
					end else if (op == OP_WRQ) begin
						sess_mode = MODE_WRITE;
						cur_block = 16'd1;
						retry_cnt = '0;
						emit(ACT_SEND, OP_ACK, '0, HeaderLen, ErrNone, 1'b0);
					end else begin
						emit(ACT_SEND, OP_ERROR, '0, HeaderLen, ErrIllegal, 1'b0);
					end
				end
			end
			CMD_CHUNK: begin
				if (sess_mode == MODE_FETCH) begin
					chunk_len = (len < eff) ? len : eff;
					if (reg_retry_limit == 8'd0) begin
						close_session(1'b1);
					end else begin
						retry_cnt = 8'd1;
						sess_mode = MODE_WAIT_ACK;
						send_chunk();
					end
				end
			end
			default: begin
				if (sess_mode == MODE_WAIT_ACK) begin
					if (cmd == CMD_PACKET && op == OP_ACK && blk == cur_block) begin
						if (chunk_len < eff) begin
							close_session(1'b0);
						end else begin
							cur_block = cur_block + 16'd1;
							retry_cnt = '0;
							sess_mode = MODE_FETCH;
							emit(ACT_FETCH, OP_NONE, cur_block, '0, ErrNone, 1'b0);
						end
					end else if (retry_cnt >= reg_retry_limit) begin
						close_session(1'b1);
					end else begin
						retry_cnt = retry_cnt + 8'd1;
						send_chunk();
					end
				end else if (sess_mode == MODE_WRITE) begin
					if (cmd == CMD_TIMEOUT || op == OP_ERROR) begin
						close_session(1'b1);
					end else if (op == OP_DATA && blk == cur_block) begin
						emit(ACT_DELIVER, OP_NONE, cur_block, len, ErrNone, 1'b0);
						if (!sink) begin
							close_session(1'b1);
						end else begin
							emit(ACT_SEND, OP_ACK, cur_block, HeaderLen, ErrNone, 1'b0);
							if (len < eff)
								close_session(1'b0);
							else
								cur_block = cur_block + 16'd1;
						end
					end
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic void add_event(logic [1:0] cmd, logic [2:0] op, logic [15:0] blk,
			logic [9:0] len, logic sink, logic typed, reply_t want);
		stim_row_t row;
		row           = '0;
		row.cmd       = cmd;
		row.op        = op;
		row.blk       = blk;
		row.len       = len;
		row.sink      = sink;
		row.typed     = typed;
		row.want      = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_setting(logic [3:0] idx, logic [9:0] val);
		stim_row_t row;
		row           = '0;
		row.is_cfg    = 1'b1;
		row.reg_index = idx;
		row.reg_value = val;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [9:0] pick_length(logic [9:0] eff);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 10'($urandom);
			2, 3, 4: return 10'($urandom_range(0, eff - 1));
			default: return eff;
		endcase
	endfunction

	task automatic offer_event(input logic [1:0] cmd, input logic [2:0] op,
			input logic [15:0] blk, input logic [9:0] len, input logic sink,
			input logic typed, input reply_t want);
		reply_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {2'b00, sink, len, blk, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_event(cmd, op, blk, len, sink);
		if (step_replies.size() > 0) begin
			r = step_replies.pop_back();
			r.last = 1'b1;
			step_replies.push_back(r);
			items_effective++;
		end
		if (typed) begin
			step_replies.delete();
			expected_replies.push_back(want);
		end
		while (step_replies.size() > 0)
			expected_replies.push_back(step_replies.pop_front());
		items_sent++;
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
		end
	endtask

	task automatic write_register(input logic [3:0] idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BLOCK_SIZE)
			reg_blksize = val;
		else if (idx == CFG_RETRY_LIMIT)
			reg_retry_limit = val[7:0];
		settings_done++;
		@(posedge clk);
	endtask

	task automatic settle();
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// Mostly well-formed session traffic, with random noise in between.
	task automatic next_random_event(output logic [1:0] cmd, output logic [2:0] op,
			output logic [15:0] blk, output logic [9:0] len, output logic sink);
		logic [9:0] eff;
		int         roll;
		eff  = eff_size();
		roll = $urandom_range(0, 99);
		cmd  = 2'($urandom);
		op   = 3'($urandom);
		blk  = 16'($urandom);
		len  = 10'($urandom);
		sink = 1'($urandom);
		case (sess_mode)
			MODE_IDLE: begin
				if (roll < 45) begin
					cmd = CMD_REQUEST;
					op  = OP_RRQ;
				end else if (roll < 85) begin
					cmd = CMD_REQUEST;
					op  = OP_WRQ;
				end else if (roll < 90) begin
					cmd = CMD_REQUEST;
				end
			end
			MODE_FETCH: begin
				if (roll < 85) begin
					cmd = CMD_CHUNK;
					len = pick_length(eff);
				end
			end
			MODE_WAIT_ACK: begin
				if (roll < 70) begin
					cmd = CMD_PACKET;
					op  = OP_ACK;
					blk = cur_block;
				end else if (roll < 85) begin
					cmd = CMD_TIMEOUT;
				end
			end
			default: begin
				if (roll < 75) begin
					cmd  = CMD_PACKET;
					op   = OP_DATA;
					blk  = cur_block;
					len  = pick_length(eff);
					sink = (roll < 70);
				end else if (roll < 80) begin
					cmd = CMD_TIMEOUT;
				end else if (roll < 85) begin
					cmd = CMD_PACKET;
					op  = OP_ERROR;
				end
			end
		endcase
	endtask

	task automatic run_phase(input logic [9:0] bsize, input logic [9:0] rlimit,
			input int count, input bit with_gaps);
		logic [1:0]  cmd;
		logic [2:0]  op;
		logic [15:0] blk;
		logic [9:0]  len;
		logic        sink;
		int          target;
		settle();
		write_register(CFG_BLOCK_SIZE, bsize);
		write_register(CFG_RETRY_LIMIT, rlimit);
		gaps_on    = with_gaps;
		burst_left = $urandom_range(1, 8);
		target     = items_effective + count;
		while (items_effective < target) begin
			next_random_event(cmd, op, blk, len, sink);
			offer_event(cmd, op, blk, len, sink, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin : receiver
		int span;
		int style;
		bit held;
		held          = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			style = $urandom_range(0, 2);
			span  = $urandom_range(20, 60);
			repeat (span) begin
				@(posedge clk);
				if (long_hold && !held) begin
					held = 1'b1;
					m_axis_tready <= 1'b0;
					repeat (LongHoldCycles) @(posedge clk);
				end
				case (style)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= 1'($urandom);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		reply_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			replies_seen++;
			if (expected_replies.size() == 0) begin
				$error("result with nothing expected: action %0d, block %0d",
					m_axis_tuser, m_axis_tdata[18:3]);
				failures++;
			end else begin
				want = expected_replies.pop_front();
				check_field("action", want.res.action, m_axis_tuser);
				check_field("send_opcode", want.res.send_opcode, m_axis_tdata[2:0]);
				check_field("send_block", want.res.send_block, m_axis_tdata[18:3]);
				check_field("send_length", want.res.send_length, m_axis_tdata[28:19]);
				check_field("error_code", want.res.error_code, m_axis_tdata[31:29]);
				check_field("end_status", want.res.end_status, m_axis_tdata[32]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		int        i;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;

		add_setting(CFG_BLOCK_SIZE, 10'd8);
		add_setting(CFG_RETRY_LIMIT, 10'd2);
		add_event(CMD_REQUEST, 3'd7, 16'd0, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_SEND, OP_ERROR, '0, HeaderLen, ErrIllegal, 1'b0, 1'b1));
		add_event(CMD_PACKET, OP_NONE, 16'hFFFF, 10'h3FF, 1'b1, 1'b0, '0);
		add_event(CMD_CHUNK, OP_NONE, 16'd0, 10'd8, 1'b0, 1'b0, '0);
		add_event(CMD_REQUEST, OP_RRQ, 16'd0, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_FETCH, OP_NONE, 16'd1, '0, ErrNone, 1'b0, 1'b1));
		add_event(CMD_REQUEST, OP_WRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_ACK, 16'd1, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_CHUNK, OP_NONE, 16'd0, 10'h3FF, 1'b0, 1'b0, '0);
		add_event(CMD_TIMEOUT, OP_NONE, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_ACK, 16'd2, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_END, OP_NONE, '0, '0, ErrNone, 1'b1, 1'b1));
		add_event(CMD_REQUEST, OP_RRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_CHUNK, OP_NONE, 16'd0, 10'd8, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_ACK, 16'd1, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_CHUNK, OP_NONE, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_ACK, 16'd2, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_REQUEST, OP_WRQ, 16'd0, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_SEND, OP_ACK, '0, HeaderLen, ErrNone, 1'b0, 1'b1));
		add_event(CMD_PACKET, OP_DATA, 16'd1, 10'd8, 1'b1, 1'b0, '0);
		add_event(CMD_PACKET, OP_DATA, 16'd5, 10'd3, 1'b1, 1'b0, '0);
		add_event(CMD_PACKET, OP_ACK, 16'd2, 10'd3, 1'b1, 1'b0, '0);
		add_event(CMD_PACKET, OP_DATA, 16'd2, 10'd3, 1'b1, 1'b0, '0);
		add_event(CMD_REQUEST, OP_WRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_DATA, 16'd1, 10'd8, 1'b0, 1'b0, '0);
		add_event(CMD_REQUEST, OP_WRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_TIMEOUT, OP_NONE, 16'd0, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_END, OP_NONE, '0, '0, ErrNone, 1'b1, 1'b1));
		add_event(CMD_REQUEST, OP_WRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_PACKET, OP_ERROR, 16'd0, 10'd0, 1'b0, 1'b1,
			make_reply(ACT_END, OP_NONE, '0, '0, ErrNone, 1'b1, 1'b1));
		add_setting(CFG_RETRY_LIMIT, 10'd0);
		add_event(CMD_REQUEST, OP_RRQ, 16'd0, 10'd0, 1'b0, 1'b0, '0);
		add_event(CMD_CHUNK, OP_NONE, 16'd0, 10'd5, 1'b0, 1'b1,
			make_reply(ACT_END, OP_NONE, '0, '0, ErrNone, 1'b1, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 8);
		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				s_axis_tvalid <= 1'b0;
				settle();
				write_register(row.reg_index, row.reg_value);
			end else begin
				offer_event(row.cmd, row.op, row.blk, row.len, row.sink, row.typed, row.want);
			end
		end
		s_axis_tvalid <= 1'b0;

		run_phase(10'd512, 10'd5, 20, 1'b1);
		settle();
		write_register(CfgUnmapped, 10'h2AA);
		run_phase(10'h3FF, 10'h3FF, 20, 1'b1);
		run_phase(10'd8, 10'd0, 15, 1'b1);
		settle();
		long_hold <= 1'b1;
		run_phase(10'($urandom_range(8, 512)), 10'($urandom_range(1, 4)), 15, 1'b0);
		settle();

		$display("Run covered %0d events (%0d with results), %0d result items, %0d register writes.",
			items_sent, items_effective, replies_seen, settings_done);
		$display("Sessions closed: %0d completed, %0d failed.", sessions_ok, sessions_failed);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
